[hw/rtl/silhouette_edge_octave_counter_top_assert.svh]
// Assertion macros for the silhouette edge octave counter top level
`ifndef SILHOUETTE_EDGE_OCTAVE_COUNTER_TOP_ASSERT_SVH
`define SILHOUETTE_EDGE_OCTAVE_COUNTER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SEOC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SEOC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/seoc_pkg.sv]
// Shared types, constants and helpers of the silhouette edge octave counter
package seoc_pkg;

  localparam int OctaveBinsDef = 20;
  localparam int AngleCountDef = 4;
  localparam int StoredFaces   = 4;
  localparam int LowestOctave  = -4;
  localparam int CoordFracBits = 16;

  localparam int CoordW  = 32;
  localparam int CntW    = 32;
  localparam int DMagW   = 34;
  localparam int EMagW   = 33;
  localparam int CrossW  = 67;
  localparam int DiffW   = 68;
  localparam int SW      = 68;
  localparam int S2W     = 136;
  localparam int C2W     = 136;
  localparam int MulAW   = 136;
  localparam int MulBW   = 68;
  localparam int ProdW   = 200;
  localparam int LhsW    = 202;
  localparam int AngRegs = 4;
  localparam int CfgIdxW = 3;
  localparam int QueueDepth = 2;

  localparam logic [CntW-1:0] Angle0Rst = 32'd74961321;
  localparam logic [CntW-1:0] Angle1Rst = 32'd37480660;
  localparam logic [CntW-1:0] Angle2Rst = 32'd7496132;
  localparam logic [CntW-1:0] Angle3Rst = 32'd0;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RCV_X  = 3'd0,
    CFG_RCV_Y  = 3'd1,
    CFG_RCV_Z  = 3'd2,
    CFG_ANG_0  = 3'd3,
    CFG_ANG_1  = 3'd4,
    CFG_ANG_2  = 3'd5,
    CFG_ANG_3  = 3'd6
  } cfg_idx_e;

  typedef logic [AngRegs-1:0][CntW-1:0] angle_vec_t;

  typedef struct packed {
    logic                       kind;
    logic                       sil;
    logic                       skip;
    logic                       nm;
    logic [2:0][DMagW-1:0]      dmag;
    logic [2:0]                 dneg;
    logic [2:0][EMagW-1:0]      emag;
    logic [2:0]                 eneg;
    logic [6:0]                 cidx;
  } job_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    sat_inc = (&v) ? v : v + 1'b1;
  endfunction

endpackage

[hw/rtl/seoc_front.sv]
// Front end: classifies an edge and forms the receiver and edge vectors
module seoc_front (
  input  logic                            kind_i,
  input  logic signed [31:0]              end_a_x_i,
  input  logic signed [31:0]              end_a_y_i,
  input  logic signed [31:0]              end_a_z_i,
  input  logic signed [31:0]              end_b_x_i,
  input  logic signed [31:0]              end_b_y_i,
  input  logic signed [31:0]              end_b_z_i,
  input  logic [7:0]                      face_count_i,
  input  logic [3:0]                      face_front_i,
  input  logic [6:0]                      counter_index_i,
  input  logic signed [31:0]              rcv_x_i,
  input  logic signed [31:0]              rcv_y_i,
  input  logic signed [31:0]              rcv_z_i,
  output seoc_pkg::job_t                  job_o
);
  import seoc_pkg::*;

  logic [CoordW-1:0]        pa [3];
  logic [CoordW-1:0]        pb [3];
  logic [CoordW-1:0]        pr [3];
  logic [34:0]              d  [3];
  logic [34:0]              nd [3];
  logic [33:0]              e  [3];
  logic [33:0]              ne [3];
  logic [StoredFaces+3:0]   ffw;
  logic [StoredFaces-1:0]   ffx;
  logic [StoredFaces-1:0]   sm;
  logic [StoredFaces-1:0]   fsel;
  logic                     dzero;

  assign pa[0] = end_a_x_i;
  assign pa[1] = end_a_y_i;
  assign pa[2] = end_a_z_i;
  assign pb[0] = end_b_x_i;
  assign pb[1] = end_b_y_i;
  assign pb[2] = end_b_z_i;
  assign pr[0] = rcv_x_i;
  assign pr[1] = rcv_y_i;
  assign pr[2] = rcv_z_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d[i]  = {{2{pr[i][31]}}, pr[i], 1'b0} - {{3{pa[i][31]}}, pa[i]}
              - {{3{pb[i][31]}}, pb[i]};
      nd[i] = 35'd0 - d[i];
      e[i]  = {{2{pb[i][31]}}, pb[i]} - {{2{pa[i][31]}}, pa[i]};
      ne[i] = 34'd0 - e[i];
    end
  end

  assign ffw = {{StoredFaces{1'b0}}, face_front_i};
  assign ffx = ffw[StoredFaces-1:0];

  always_comb begin
    for (int i = 0; i < StoredFaces; i++) begin
      sm[i] = face_count_i > 8'(i);
    end
  end

  assign fsel  = ffx & sm;
  assign dzero = (d[0] == '0) && (d[1] == '0) && (d[2] == '0);

  always_comb begin
    job_o      = '0;
    job_o.kind = kind_i;
    job_o.cidx = counter_index_i;
    job_o.sil  = (face_count_i >= 8'd2) && (fsel != '0) && (fsel != sm);
    job_o.skip = job_o.sil && dzero;
    job_o.nm   = face_count_i > 8'd2;
    for (int i = 0; i < 3; i++) begin
      job_o.dneg[i] = d[i][34];
      job_o.dmag[i] = d[i][34] ? nd[i][DMagW-1:0] : d[i][DMagW-1:0];
      job_o.eneg[i] = e[i][33];
      job_o.emag[i] = e[i][33] ? ne[i][EMagW-1:0] : e[i][EMagW-1:0];
    end
  end

endmodule

[hw/rtl/seoc_queue.sv]
// Short job queue between the front end and the back end
module seoc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  seoc_pkg::job_t data_i,
  output logic           valid_o,
  input  logic           pop_i,
  output seoc_pkg::job_t data_o
);
  import seoc_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntWq = $clog2(QueueDepth + 1);

  job_t              buf_q [QueueDepth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntWq-1:0]  cnt_q;
  logic              do_push, do_pop;

  assign full_o  = cnt_q == CntWq'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = buf_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/seoc_mul.sv]
// Shift-add multiplier, one multiplier bit per cycle
module seoc_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [seoc_pkg::MulAW-1:0]    a_i,
  input  logic [seoc_pkg::MulBW-1:0]    b_i,
  output logic                          done_o,
  output logic [seoc_pkg::ProdW-1:0]    p_o
);
  import seoc_pkg::*;

  logic [ProdW-1:0] a_q, p_q;
  logic [MulBW-1:0] b_q;
  logic             busy_q;

  assign done_o = busy_q && (b_q == '0);
  assign p_o    = p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      a_q    <= '0;
      b_q    <= '0;
      p_q    <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      a_q    <= {{(ProdW-MulAW){1'b0}}, a_i};
      b_q    <= b_i;
      p_q    <= '0;
    end else if (busy_q) begin
      if (b_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        if (b_q[0]) begin
          p_q <= p_q + a_q;
        end
        a_q <= a_q << 1;
        b_q <= b_q >> 1;
      end
    end
  end

endmodule

[hw/rtl/seoc_back.sv]
// Back end: angle tests, octave search, counter updates and result slot
module seoc_back #(
  parameter int OctaveBins = seoc_pkg::OctaveBinsDef,
  parameter int AngleCount = seoc_pkg::AngleCountDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       job_valid_i,
  input  seoc_pkg::job_t             job_i,
  output logic                       job_pop_o,
  input  seoc_pkg::angle_vec_t       angle_i,
  input  logic                       pop_i,
  output logic                       empty_o,
  output logic                       is_silhouette_o,
  output logic                       skipped_o,
  output logic                       nonmanifold_o,
  output logic [4:0]                 octave_bin_o,
  output logic [3:0]                 survive_mask_o,
  output logic [31:0]                counter_value_o
);
  import seoc_pkg::*;

  localparam int MemDepth = OctaveBins * (AngleCount + 1);
  localparam int MemAw    = $clog2(MemDepth);
  localparam int KW       = $clog2(OctaveBins);
  localparam int Off      = 1 + CoordFracBits + LowestOctave;
  localparam int NmBase   = MemDepth;
  localparam int SkipIdx  = MemDepth + AngleCount + 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_ISSUE, ST_WAIT, ST_SCAN, ST_UPD, ST_RMW_RD, ST_RMW_WR, ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    PH_SQ, PH_S2, PH_CR, PH_DF, PH_AN, PH_AR
  } phase_e;

  state_e                state_q;
  phase_e                phase_q;
  job_t                  job_q;
  logic [2:0]            idx_q;
  logic [2:0]            u_q;
  logic [SW-1:0]         s_q, scan_q;
  logic [S2W-1:0]        s2_q;
  logic [C2W-1:0]        c2_q;
  logic [CrossW-1:0]     prod_q;
  logic                  prodneg_q;
  logic [DiffW-1:0]      diff_q [3];
  logic [63:0]           ang2_q;
  logic [3:0]            mask_q;
  logic [6:0]            m_q;
  logic [KW-1:0]         k_q;
  logic [CntW-1:0]       nm_total_q, skip_q;
  logic [CntW-1:0]       nm_surv_q [AngRegs];
  logic                  res_sil_q, res_skip_q, res_nm_q;
  logic [CntW-1:0]       res_val_q;
  logic                  out_valid_q, out_sil_q, out_skip_q, out_nm_q;
  logic [KW-1:0]         out_oct_q;
  logic [3:0]            out_mask_q;
  logic [CntW-1:0]       out_val_q;

  logic                  mul_start, mul_done, cr_neg;
  logic [MulAW-1:0]      mul_a;
  logic [MulBW-1:0]      mul_b;
  logic [ProdW-1:0]      mul_p;
  logic [1:0]            ei, di;
  logic [69:0]           v1, v2, dv, adv;
  logic [LhsW-1:0]       lhs;
  logic signed [8:0]     kk;
  logic [KW-1:0]         kc;
  logic [CntW-1:0]       flop_val, mem_rd;
  logic [CntW-1:0]       cidx_w, sidx;
  logic                  in_mem, slot_free, upd_en;
  logic [MemAw+6:0]      cidx_x;
  logic [MemAw-1:0]      upd_addr, mem_raddr;
  logic [KW+4:0]         oct_x;

  logic [CntW-1:0]       mem_q [MemDepth];
  logic [MemDepth-1:0]   vld_q;
  logic [CntW-1:0]       rdata_q;
  logic                  rvld_q;
  logic                  mem_we;

  seoc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  assign mul_start = state_q == ST_ISSUE;
  assign job_pop_o = (state_q == ST_IDLE) && job_valid_i;
  assign slot_free = !out_valid_q || pop_i;

  // cross product term pairs: e index and D index
  always_comb begin
    case (idx_q)
      3'd0:    begin ei = 2'd1; di = 2'd2; end
      3'd1:    begin ei = 2'd2; di = 2'd1; end
      3'd2:    begin ei = 2'd2; di = 2'd0; end
      3'd3:    begin ei = 2'd0; di = 2'd2; end
      3'd4:    begin ei = 2'd0; di = 2'd1; end
      3'd5:    begin ei = 2'd1; di = 2'd0; end
      default: begin ei = 2'd0; di = 2'd0; end
    endcase
  end

  assign cr_neg = job_q.eneg[ei] ^ job_q.dneg[di];

  always_comb begin
    case (phase_q)
      PH_SQ: begin
        mul_a = MulAW'(job_q.dmag[idx_q[1:0]]);
        mul_b = MulBW'(job_q.dmag[idx_q[1:0]]);
      end
      PH_S2: begin
        mul_a = MulAW'(s_q);
        mul_b = s_q;
      end
      PH_CR: begin
        mul_a = MulAW'(job_q.emag[ei]);
        mul_b = MulBW'(job_q.dmag[di]);
      end
      PH_DF: begin
        mul_a = MulAW'(diff_q[idx_q[1:0]]);
        mul_b = diff_q[idx_q[1:0]];
      end
      PH_AN: begin
        mul_a = MulAW'(angle_i[idx_q[1:0]]);
        mul_b = MulBW'(angle_i[idx_q[1:0]]);
      end
      PH_AR: begin
        mul_a = s2_q;
        mul_b = MulBW'(ang2_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    v1  = prodneg_q ? 70'd0 - {3'b0, prod_q} : {3'b0, prod_q};
    v2  = cr_neg ? 70'd0 - {3'b0, mul_p[CrossW-1:0]} : {3'b0, mul_p[CrossW-1:0]};
    dv  = v1 - v2;
    adv = dv[69] ? 70'd0 - dv : dv;
  end

  assign lhs = {c2_q, 66'b0};

  // octave index from the top set bit of |D|^2
  always_comb begin
    kk = $signed({3'b0, m_q[6:1]}) - $signed(9'(Off));
    if (kk < 0) begin
      kc = '0;
    end else if (kk > $signed(9'(OctaveBins - 1))) begin
      kc = KW'(OctaveBins - 1);
    end else begin
      kc = kk[KW-1:0];
    end
  end

  assign cidx_w = {25'b0, job_i.cidx};
  assign in_mem = cidx_w < 32'(MemDepth);
  assign sidx   = cidx_w - 32'(NmBase + 1);

  always_comb begin
    if (cidx_w == 32'(NmBase)) begin
      flop_val = nm_total_q;
    end else if (cidx_w > 32'(NmBase) && cidx_w <= 32'(NmBase + AngleCount)) begin
      flop_val = nm_surv_q[sidx[1:0]];
    end else if (cidx_w == 32'(SkipIdx)) begin
      flop_val = skip_q;
    end else begin
      flop_val = '0;
    end
  end

  assign cidx_x    = {{MemAw{1'b0}}, job_i.cidx};
  assign upd_addr  = MemAw'(int'(u_q) * OctaveBins + int'(k_q));
  assign mem_raddr = (state_q == ST_IDLE) ? (in_mem ? cidx_x[MemAw-1:0] : '0) : upd_addr;
  assign upd_en    = (u_q == '0) || mask_q[2'(u_q - 3'd1)];
  assign mem_we    = (state_q == ST_RMW_WR) && upd_en;
  assign mem_rd    = rvld_q ? rdata_q : '0;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[upd_addr] <= sat_inc(mem_rd);
    end
    rdata_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_q[upd_addr] <= 1'b1;
      end
      rvld_q <= vld_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_SQ;
      job_q       <= '0;
      idx_q       <= '0;
      u_q         <= '0;
      s_q         <= '0;
      scan_q      <= '0;
      s2_q        <= '0;
      c2_q        <= '0;
      prod_q      <= '0;
      prodneg_q   <= 1'b0;
      for (int i = 0; i < 3; i++) diff_q[i] <= '0;
      ang2_q      <= '0;
      mask_q      <= '0;
      m_q         <= '0;
      k_q         <= '0;
      nm_total_q  <= '0;
      skip_q      <= '0;
      for (int i = 0; i < AngRegs; i++) nm_surv_q[i] <= '0;
      res_sil_q   <= 1'b0;
      res_skip_q  <= 1'b0;
      res_nm_q    <= 1'b0;
      res_val_q   <= '0;
      out_valid_q <= 1'b0;
      out_sil_q   <= 1'b0;
      out_skip_q  <= 1'b0;
      out_nm_q    <= 1'b0;
      out_oct_q   <= '0;
      out_mask_q  <= '0;
      out_val_q   <= '0;
    end else begin
      if (pop_i && out_valid_q && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            job_q      <= job_i;
            res_sil_q  <= !job_i.kind && job_i.skip;
            res_skip_q <= !job_i.kind && job_i.skip;
            res_nm_q   <= 1'b0;
            res_val_q  <= (job_i.kind && !in_mem) ? flop_val : '0;
            s_q        <= '0;
            c2_q       <= '0;
            mask_q     <= '0;
            k_q        <= '0;
            idx_q      <= '0;
            phase_q    <= PH_SQ;
            if (job_i.kind) begin
              if (in_mem) begin
                state_q <= ST_READ;
              end else begin
                state_q <= ST_DONE;
              end
            end else if (!job_i.sil) begin
              state_q <= ST_DONE;
            end else if (job_i.skip) begin
              skip_q  <= sat_inc(skip_q);
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_ISSUE;
            end
          end
        end
        ST_READ: begin
          res_val_q <= mem_rd;
          state_q   <= ST_DONE;
        end
        ST_ISSUE: begin
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (mul_done) begin
            state_q <= (phase_q == PH_AR && idx_q == 3'(AngleCount - 1)) ? ST_SCAN : ST_ISSUE;
            case (phase_q)
              PH_SQ: begin
                s_q <= s_q + mul_p[SW-1:0];
                if (idx_q == 3'd2) begin
                  idx_q   <= '0;
                  phase_q <= PH_S2;
                end else begin
                  idx_q <= idx_q + 1'b1;
                end
              end
              PH_S2: begin
                s2_q    <= mul_p[S2W-1:0];
                idx_q   <= '0;
                phase_q <= PH_CR;
              end
              PH_CR: begin
                if (!idx_q[0]) begin
                  prod_q    <= mul_p[CrossW-1:0];
                  prodneg_q <= cr_neg;
                end else begin
                  diff_q[idx_q[2:1]] <= adv[DiffW-1:0];
                end
                if (idx_q == 3'd5) begin
                  idx_q   <= '0;
                  phase_q <= PH_DF;
                end else begin
                  idx_q <= idx_q + 1'b1;
                end
              end
              PH_DF: begin
                c2_q <= c2_q + mul_p[C2W-1:0];
                if (idx_q == 3'd2) begin
                  idx_q   <= '0;
                  phase_q <= PH_AN;
                end else begin
                  idx_q <= idx_q + 1'b1;
                end
              end
              PH_AN: begin
                ang2_q  <= mul_p[63:0];
                phase_q <= PH_AR;
              end
              PH_AR: begin
                mask_q[idx_q[1:0]] <= lhs >= {2'b0, mul_p};
                if (idx_q == 3'(AngleCount - 1)) begin
                  scan_q <= s_q;
                  m_q    <= '0;
                end else begin
                  idx_q   <= idx_q + 1'b1;
                  phase_q <= PH_AN;
                end
              end
              default: begin
                phase_q <= PH_SQ;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (scan_q[SW-1:1] != '0) begin
            scan_q <= scan_q >> 1;
            m_q    <= m_q + 1'b1;
          end else begin
            k_q     <= kc;
            state_q <= ST_UPD;
          end
        end
        ST_UPD: begin
          res_sil_q <= 1'b1;
          if (job_q.nm) begin
            res_nm_q   <= 1'b1;
            nm_total_q <= sat_inc(nm_total_q);
            for (int q = 0; q < AngleCount; q++) begin
              if (mask_q[q]) nm_surv_q[q] <= sat_inc(nm_surv_q[q]);
            end
            state_q <= ST_DONE;
          end else begin
            u_q     <= '0;
            state_q <= ST_RMW_RD;
          end
        end
        ST_RMW_RD: begin
          state_q <= ST_RMW_WR;
        end
        ST_RMW_WR: begin
          if (u_q == 3'(AngleCount)) begin
            state_q <= ST_DONE;
          end else begin
            u_q     <= u_q + 1'b1;
            state_q <= ST_RMW_RD;
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_sil_q   <= res_sil_q;
            out_skip_q  <= res_skip_q;
            out_nm_q    <= res_nm_q;
            out_oct_q   <= (res_sil_q && !res_skip_q) ? k_q : '0;
            out_mask_q  <= (res_sil_q && !res_skip_q) ? mask_q : '0;
            out_val_q   <= res_val_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign oct_x           = {5'b0, out_oct_q};
  assign empty_o         = !out_valid_q;
  assign is_silhouette_o = out_sil_q;
  assign skipped_o       = out_skip_q;
  assign nonmanifold_o   = out_nm_q;
  assign octave_bin_o    = oct_x[4:0];
  assign survive_mask_o  = out_mask_q;
  assign counter_value_o = out_val_q;

endmodule

[hw/rtl/silhouette_edge_octave_counter_top.sv]
// Silhouette edge octave counter: top level with configuration registers.
// Items are processed one at a time. A counter read, an edge that is not a silhouette and an
// edge whose midpoint sits on the receiver skip the multiplier. A classified edge runs 21
// products through one shared shift-add multiplier, whose time grows with the top set bit
// of each second operand, then a top-bit search of |D|^2 and, for a manifold edge, a
// read-modify-write of each updated counter in the counter memory. A two-entry queue lets
// new items enter while the back end works, and one result register holds a finished result
// until it is popped. Counters come out of reset cleared at once.
module silhouette_edge_octave_counter_top #(
  parameter int OctaveBins = seoc_pkg::OctaveBinsDef,
  parameter int AngleCount = seoc_pkg::AngleCountDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic                              kind_i,
  input  logic signed [31:0]                end_a_x_i,
  input  logic signed [31:0]                end_a_y_i,
  input  logic signed [31:0]                end_a_z_i,
  input  logic signed [31:0]                end_b_x_i,
  input  logic signed [31:0]                end_b_y_i,
  input  logic signed [31:0]                end_b_z_i,
  input  logic [7:0]                        face_count_i,
  input  logic [3:0]                        face_front_i,
  input  logic [6:0]                        counter_index_i,
  output logic                              empty,
  input  logic                              pop,
  output logic                              is_silhouette_o,
  output logic                              skipped_o,
  output logic                              nonmanifold_o,
  output logic [4:0]                        octave_bin_o,
  output logic [3:0]                        survive_mask_o,
  output logic [31:0]                       counter_value_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [seoc_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [31:0]                       cfg_data_i
);
  import seoc_pkg::*;

  logic [CoordW-1:0] rcv_x_q, rcv_y_q, rcv_z_q;
  angle_vec_t        angle_q;
  job_t              front_job, q_job;
  logic              q_valid, q_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcv_x_q    <= '0;
      rcv_y_q    <= '0;
      rcv_z_q    <= '0;
      angle_q[0] <= Angle0Rst;
      angle_q[1] <= Angle1Rst;
      angle_q[2] <= Angle2Rst;
      angle_q[3] <= Angle3Rst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_RCV_X: rcv_x_q    <= cfg_data_i;
        CFG_RCV_Y: rcv_y_q    <= cfg_data_i;
        CFG_RCV_Z: rcv_z_q    <= cfg_data_i;
        CFG_ANG_0: angle_q[0] <= cfg_data_i;
        CFG_ANG_1: angle_q[1] <= cfg_data_i;
        CFG_ANG_2: angle_q[2] <= cfg_data_i;
        CFG_ANG_3: angle_q[3] <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  seoc_front u_front (
    .kind_i          (kind_i),
    .end_a_x_i       (end_a_x_i),
    .end_a_y_i       (end_a_y_i),
    .end_a_z_i       (end_a_z_i),
    .end_b_x_i       (end_b_x_i),
    .end_b_y_i       (end_b_y_i),
    .end_b_z_i       (end_b_z_i),
    .face_count_i    (face_count_i),
    .face_front_i    (face_front_i),
    .counter_index_i (counter_index_i),
    .rcv_x_i         (rcv_x_q),
    .rcv_y_i         (rcv_y_q),
    .rcv_z_i         (rcv_z_q),
    .job_o           (front_job)
  );

  seoc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .data_i  (front_job),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_job)
  );

  seoc_back #(
    .OctaveBins (OctaveBins),
    .AngleCount (AngleCount)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (q_valid),
    .job_i           (q_job),
    .job_pop_o       (q_pop),
    .angle_i         (angle_q),
    .pop_i           (pop),
    .empty_o         (empty),
    .is_silhouette_o (is_silhouette_o),
    .skipped_o       (skipped_o),
    .nonmanifold_o   (nonmanifold_o),
    .octave_bin_o    (octave_bin_o),
    .survive_mask_o  (survive_mask_o),
    .counter_value_o (counter_value_o)
  );

`include "silhouette_edge_octave_counter_top_assert.svh"

  `SEOC_ASSERT_NEXT(a_push_queued, push && !full, q_valid, "accepted item not queued")
  `SEOC_ASSERT_NOW(a_nonsil_clean, !empty && !is_silhouette_o,
                   !skipped_o && !nonmanifold_o && survive_mask_o == 4'd0,
                   "non-silhouette result carries edge flags")
  `SEOC_ASSERT_NOW(a_skip_clean, !empty && skipped_o,
                   survive_mask_o == 4'd0 && octave_bin_o == 5'd0 && !nonmanifold_o,
                   "skipped edge carries classification")
  `SEOC_ASSERT_NOW(a_read_clean, !empty && counter_value_o != 32'd0, !is_silhouette_o,
                   "counter read marked as silhouette")

endmodule
